[sv/dtpd_pkg.sv]
// Shared widths, reset values, register indexes and types of the drum trigger
// peak detector. No dependencies; used by dtpd_div and drum_trigger_peak_detector.
package dtpd_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int DURATION_BITS = 20;
  localparam int TIME_BITS     = 32;
  localparam int CHANNEL_BITS  = 8;
  localparam int PHASE_BITS    = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // |peak - base| * elapsed
  localparam int PROD_BITS = SAMPLE_BITS + DURATION_BITS;
  localparam int CNT_BITS  = $clog2(SAMPLE_BITS);

  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS =
      ((1 + SAMPLE_BITS + CHANNEL_BITS + PHASE_BITS + 7) / 8) * 8;

  localparam logic [SAMPLE_BITS-1:0]   BASE_THR_RST  = SAMPLE_BITS'(10);
  localparam logic [DURATION_BITS-1:0] SCAN_TIME_RST = DURATION_BITS'(10000);
  localparam logic [DURATION_BITS-1:0] MASK_TIME_RST = DURATION_BITS'(10000);
  localparam logic [DURATION_BITS-1:0] RAMP_TIME_RST = DURATION_BITS'(350000);
  localparam logic [CHANNEL_BITS-1:0]  CHANNEL_RST   = '0;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_THR  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCAN_TIME = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MASK_TIME = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_TIME = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL   = 3'd4;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE = 2'd0,
    PH_SCAN = 2'd1,
    PH_MASK = 2'd2,
    PH_RAMP = 2'd3
  } phase_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[sv/dtpd_div.sv]
// Bit-serial restoring divider for the retrigger ramp, one quotient bit per cycle.
// Depends on dtpd_pkg. Caller guarantees dividend < divisor << SAMPLE_BITS.
module dtpd_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [dtpd_pkg::PROD_BITS-1:0]       dividend_i,
  input  logic [dtpd_pkg::DURATION_BITS-1:0]   divisor_i,
  output dtpd_pkg::div_status_t                status_o,
  output logic [dtpd_pkg::SAMPLE_BITS-1:0]     quot_o
);

  localparam int SB = dtpd_pkg::SAMPLE_BITS;
  localparam int DB = dtpd_pkg::DURATION_BITS;

  logic [DB-1:0]                 rem_q;
  logic [SB-1:0]                 lo_q;
  logic [dtpd_pkg::CNT_BITS-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;

  logic [DB:0]   trial;
  logic          ge;
  logic [DB-1:0] rem_next;

  // high bits of lo_q are the dividend going in, low bits the quotient coming out
  assign trial    = {rem_q, lo_q[SB-1]};
  assign ge       = trial >= {1'b0, divisor_i};
  assign rem_next = ge ? DB'(trial - {1'b0, divisor_i}) : trial[DB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      lo_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= dividend_i[dtpd_pkg::PROD_BITS-1:SB];
        lo_q   <= dividend_i[SB-1:0];
        cnt_q  <= dtpd_pkg::CNT_BITS'(SB - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_next;
        lo_q  <= {lo_q[SB-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = lo_q;

endmodule

[sv/drum_trigger_peak_detector.sv]
// Piezo drum trigger: idle / scan / mask / retrigger ramp phases with peak tracking.
// Depends on dtpd_pkg and dtpd_div (ramp threshold division).
//
// Channel  Dir  Handshake                  Payload (low bit first)
// s_axis   in   s_axis_tvalid/tready       tdata: sample, now_us
// m_axis   out  m_axis_tvalid/tready       tdata: hit_valid, hit_peak, hit_channel, phase
// cfg      in   cfg_valid/cfg_ready        cfg_index, cfg_data (always ready)
//
// Idle, scan and mask samples, and ramp samples past the ramp end, finish in the
// request cycle. A ramp sample inside the ramp goes through the S_MUL, S_DIV and
// S_FIN states, the bit-serial divider giving one quotient bit per cycle.
// Reset is asynchronous; registers take their reset values at once.
// One output register holds the result; a request is taken while it waits if
// the result slot frees in that cycle.
module drum_trigger_peak_detector (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [9:0] sample, [41:10] now_us
  input  logic [dtpd_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // [0] hit_valid, [10:1] hit_peak, [18:11] hit_channel, [20:19] phase
  output logic [dtpd_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [dtpd_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [dtpd_pkg::CFG_DATA_BITS-1:0]      cfg_data_i
);

  localparam int SB = dtpd_pkg::SAMPLE_BITS;
  localparam int DB = dtpd_pkg::DURATION_BITS;
  localparam int TB = dtpd_pkg::TIME_BITS;
  localparam int CB = dtpd_pkg::CHANNEL_BITS;

  typedef enum logic [1:0] {
    S_READY,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  // configuration
  logic [SB-1:0] base_q;
  logic [DB-1:0] scan_q;
  logic [DB-1:0] mask_q;
  logic [DB-1:0] ramp_q;
  logic [CB-1:0] chan_q;

  // detector state
  dtpd_pkg::phase_e phase_q, phase_d;
  logic [TB-1:0]    start_q, start_d;
  logic [SB-1:0]    peak_q, peak_d;

  state_e        st_q;
  logic [SB-1:0] sample_q;
  logic [TB-1:0] now_q;
  logic [DB-1:0] elapsed_q;

  logic             out_valid_q;
  logic             out_hit_q;
  logic [SB-1:0]    out_peak_q;
  logic [CB-1:0]    out_chan_q;
  dtpd_pkg::phase_e out_phase_q;

  logic [SB-1:0] in_sample;
  logic [TB-1:0] in_now;
  logic [TB-1:0] elapsed;
  logic          in_fire;
  logic          slot_free;
  logic          out_load;
  logic          hit;
  logic          go_div;

  logic                          h_neg;
  logic [SB-1:0]                 h_abs;
  logic [dtpd_pkg::PROD_BITS-1:0] prod;
  logic                          div_start;
  dtpd_pkg::div_status_t         div_stat;
  logic [SB-1:0]                 quot;
  logic [SB:0]                   ramp_thr;
  logic                          retrig;

  assign in_sample = s_axis_tdata_i[SB-1:0];
  assign in_now    = s_axis_tdata_i[SB+TB-1:SB];
  assign elapsed   = in_now - start_q;

  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (st_q == S_READY) && slot_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // output register takes a new result this cycle
  assign out_load = (in_fire && !go_div) || ((st_q == S_FIN) && slot_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= dtpd_pkg::BASE_THR_RST;
      scan_q <= dtpd_pkg::SCAN_TIME_RST;
      mask_q <= dtpd_pkg::MASK_TIME_RST;
      ramp_q <= dtpd_pkg::RAMP_TIME_RST;
      chan_q <= dtpd_pkg::CHANNEL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dtpd_pkg::CFG_BASE_THR:  base_q <= cfg_data_i[SB-1:0];
        dtpd_pkg::CFG_SCAN_TIME: scan_q <= cfg_data_i[DB-1:0];
        dtpd_pkg::CFG_MASK_TIME: mask_q <= cfg_data_i[DB-1:0];
        dtpd_pkg::CFG_RAMP_TIME: ramp_q <= cfg_data_i[DB-1:0];
        dtpd_pkg::CFG_CHANNEL:   chan_q <= cfg_data_i[CB-1:0];
        default: ;
      endcase
    end
  end

  // phase decisions that resolve in the request cycle, or hand a ramp sample to the divider
  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    peak_d  = peak_q;
    hit     = 1'b0;
    go_div  = 1'b0;
    case (phase_q)
      dtpd_pkg::PH_IDLE: begin
        if (in_sample > base_q) begin
          phase_d = dtpd_pkg::PH_SCAN;
          start_d = in_now;
          peak_d  = in_sample;
        end
      end
      dtpd_pkg::PH_SCAN: begin
        if (elapsed >= TB'(scan_q)) begin
          hit     = 1'b1;
          start_d = in_now;
          if (mask_q != '0) begin
            phase_d = dtpd_pkg::PH_MASK;
          end else if (ramp_q != '0) begin
            phase_d = dtpd_pkg::PH_RAMP;
          end else begin
            phase_d = dtpd_pkg::PH_IDLE;
          end
        end else if (in_sample > peak_q) begin
          peak_d = in_sample;
        end
      end
      dtpd_pkg::PH_MASK: begin
        if (elapsed >= TB'(mask_q)) begin
          start_d = in_now;
          phase_d = (ramp_q != '0) ? dtpd_pkg::PH_RAMP : dtpd_pkg::PH_IDLE;
        end
      end
      dtpd_pkg::PH_RAMP: begin
        if (elapsed >= TB'(ramp_q)) begin
          start_d = in_now;
          phase_d = dtpd_pkg::PH_IDLE;
        end else begin
          go_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ramp threshold = peak - trunc((peak - base) * t / ramp), sign handled apart
  assign h_neg     = peak_q < base_q;
  assign h_abs     = h_neg ? (base_q - peak_q) : (peak_q - base_q);
  assign prod      = dtpd_pkg::PROD_BITS'(h_abs) * dtpd_pkg::PROD_BITS'(elapsed_q);
  assign div_start = (st_q == S_MUL);

  dtpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (ramp_q),
    .status_o   (div_stat),
    .quot_o     (quot)
  );

  // quotient never exceeds |h|, so the threshold stays in [0, 2^SB)
  assign ramp_thr = h_neg ? ({1'b0, peak_q} + {1'b0, quot})
                          : ({1'b0, peak_q} - {1'b0, quot});
  assign retrig   = {1'b0, sample_q} >= ramp_thr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_READY;
      phase_q     <= dtpd_pkg::PH_IDLE;
      start_q     <= '0;
      peak_q      <= '0;
      sample_q    <= '0;
      now_q       <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_peak_q  <= '0;
      out_chan_q  <= '0;
      out_phase_q <= dtpd_pkg::PH_IDLE;
    end else begin
      if (out_valid_q && m_axis_tready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_READY: begin
          if (in_fire) begin
            if (go_div) begin
              sample_q  <= in_sample;
              now_q     <= in_now;
              elapsed_q <= elapsed[DB-1:0];
              st_q      <= S_MUL;
            end else begin
              phase_q     <= phase_d;
              start_q     <= start_d;
              peak_q      <= peak_d;
              out_valid_q <= 1'b1;
              out_hit_q   <= hit;
              out_peak_q  <= hit ? peak_q : '0;
              out_chan_q  <= hit ? chan_q : '0;
              out_phase_q <= phase_d;
            end
          end
        end
        S_MUL: begin
          st_q <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            st_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            if (retrig) begin
              phase_q <= dtpd_pkg::PH_SCAN;
              start_q <= now_q;
              peak_q  <= sample_q;
            end
            out_valid_q <= 1'b1;
            out_hit_q   <= 1'b0;
            out_peak_q  <= '0;
            out_chan_q  <= '0;
            out_phase_q <= retrig ? dtpd_pkg::PH_SCAN : dtpd_pkg::PH_RAMP;
            st_q        <= S_READY;
          end
        end
        default: st_q <= S_READY;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = dtpd_pkg::OUT_TDATA_BITS'({out_phase_q, out_chan_q,
                                                       out_peak_q, out_hit_q});

`ifndef ASSERT_OFF
  a_no_req_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !s_axis_tready_o)
    else $error("request taken while ramp division runs");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (st_q == S_DIV))
    else $error("divider finished outside the division state");

  a_fin_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN && slot_free) |=> out_valid_q && !out_hit_q)
    else $error("ramp result not placed in the output register");

  a_hit_leaves_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hit_q) |-> (out_phase_q != dtpd_pkg::PH_SCAN))
    else $error("hit reported while still scanning");
`endif

endmodule
